FILE: sv/assert_macros.svh
// Assertion helpers used by the checker sccp_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define SCCP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SCCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sccp_pkg.sv
package sccp_pkg;

  // Command line storage
  localparam int LINE_DEPTH = 128;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] KEY_ENTER     = 8'd13;
  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_ZERO       = 8'd48;

  // "start" command
  localparam int START_LEN = 5;
  localparam int IDX_W     = $clog2(START_LEN);

  // Decimal conversion: floor(v / 10) = (v * RECIP10) >> 35 for any 32-bit v
  localparam int          DIG_N     = 10;
  localparam int          CNT_W     = $clog2(DIG_N + 1);
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int          RECIP_SH  = 35;

  typedef enum logic [1:0] {
    SEL_ECHO  = 2'd0,
    SEL_LF    = 2'd1,
    SEL_CR    = 2'd2,
    SEL_DIGIT = 2'd3
  } tx_sel_t;

  // Controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    chk_step;
    logic    line_update;
    logic    conv_mul;
    logic    conv_step;
    logic    pop;
    logic    emit;
    logic    emit_last;
    tx_sel_t emit_sel;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_sample;     // request at the port is a sample
    logic in_enter_chk;  // request at the port is Enter that needs the "start" check
    logic display;
    logic chk_last;
    logic go_start;
    logic conv_end;
    logic dig_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] start_char(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h73;  // s
      3'd1:    c = 8'h74;  // t
      3'd2:    c = 8'h61;  // a
      3'd3:    c = 8'h72;  // r
      3'd4:    c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/sccp_ram.sv
module sccp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/sccp_dp.sv
module sccp_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              mode,
  input  logic [7:0]        rx_char,
  input  logic [31:0]       sample_value,
  input  sccp_pkg::cmd_t    cmd,
  output sccp_pkg::status_t st,
  input  logic              result_ready,
  output logic              result_valid,
  output logic [7:0]        tx_byte,
  output logic              last
);
  import sccp_pkg::*;

  logic [7:0]         chr;
  logic [31:0]        v;
  logic [63:0]        prod;
  logic [4*DIG_N-1:0] stack;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   idx;
  logic               match;
  logic [LEN_W-1:0]   length;
  logic               display;

  logic               wr_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;
  logic [31:0]        q;
  logic [31:0]        qx10;
  logic [31:0]        rem;
  logic               chr_enter;
  logic               chr_bksp;
  logic [7:0]         byte_mux;

  // Line store
  assign wr_en   = cmd.line_update && !chr_enter && !chr_bksp;
  assign rd_addr = {{(ADDR_W-IDX_W){1'b0}}, idx};

  sccp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (length[ADDR_W-1:0]),
    .wr_data (chr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Divide-by-ten step from the registered product
  assign q    = {{(32-(64-RECIP_SH)){1'b0}}, prod[63:RECIP_SH]};
  assign qx10 = (q << 3) + (q << 1);
  assign rem  = v - qx10;

  assign chr_enter = (chr == KEY_ENTER);
  assign chr_bksp  = (chr == KEY_BACKSPACE);

  // Status
  always_comb begin
    st.in_sample    = mode;
    st.in_enter_chk = (rx_char == KEY_ENTER) && !display && (length == LEN_W'(START_LEN));
    st.display      = display;
    st.chk_last     = (idx == IDX_W'(START_LEN - 1));
    st.go_start     = chr_enter && !display && (length == LEN_W'(START_LEN)) && match;
    st.conv_end     = (q == 32'd0) || (cnt == CNT_W'(DIG_N - 1));
    st.dig_last     = (cnt == CNT_W'(1));
    st.out_free     = !result_valid || result_ready;
  end

  // Request capture, start check and decimal conversion
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      chr   <= rx_char;
      v     <= sample_value;
      cnt   <= '0;
      idx   <= '0;
      match <= 1'b1;
    end
    if (cmd.chk_step) begin
      match <= match && (rd_data == start_char(idx));
      idx   <= idx + 1'b1;
    end
    if (cmd.conv_mul) begin
      prod <= 64'(v) * 64'(RECIP10);
    end
    if (cmd.conv_step) begin
      stack <= {stack[4*DIG_N-5:0], rem[3:0]};
      v     <= q;
      cnt   <= cnt + 1'b1;
    end
    if (cmd.pop) begin
      stack <= {4'd0, stack[4*DIG_N-1:4]};
      cnt   <= cnt - 1'b1;
    end
  end

  // Line length and display flag
  always_ff @(posedge clk) begin
    if (rst) begin
      length  <= '0;
      display <= 1'b0;
    end else if (cmd.load_item) begin
      // full line wraps to empty before the character is handled
      if (!mode && (length >= LEN_W'(LINE_DEPTH))) begin
        length <= '0;
      end
    end else if (cmd.line_update) begin
      if (chr_enter) begin
        length  <= '0;
        display <= st.go_start;
      end else if (chr_bksp) begin
        if (length != '0) begin
          length <= length - 1'b1;
        end
      end else begin
        length <= length + 1'b1;
      end
    end
  end

  // Output byte select
  always_comb begin
    case (cmd.emit_sel)
      SEL_ECHO:  byte_mux = chr;
      SEL_LF:    byte_mux = CH_LF;
      SEL_CR:    byte_mux = CH_CR;
      SEL_DIGIT: byte_mux = CH_ZERO + {4'd0, stack[3:0]};
      default:   byte_mux = chr;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tx_byte <= byte_mux;
      last    <= cmd.emit_last;
    end
  end

endmodule

FILE: sv/sccp_ctrl.sv
module sccp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sccp_pkg::status_t st,
  output sccp_pkg::cmd_t    cmd
);
  import sccp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHK_RD  = 9'b000000010,
    S_CHK_CMP = 9'b000000100,
    S_ECHO    = 9'b000001000,
    S_LF      = 9'b000010000,
    S_CR      = 9'b000100000,
    S_MUL     = 9'b001000000,
    S_DIV     = 9'b010000000,
    S_DIGIT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          if (st.in_sample) begin
            // samples are dropped while display is off
            if (st.display) begin
              state_next = S_MUL;
            end
          end else if (st.in_enter_chk) begin
            state_next = S_CHK_RD;
          end else begin
            state_next = S_ECHO;
          end
        end
      end
      S_CHK_RD: begin
        state_next = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        cmd.chk_step = 1'b1;
        state_next   = st.chk_last ? S_ECHO : S_CHK_RD;
      end
      S_ECHO: begin
        if (st.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_ECHO;
          cmd.emit_last   = !st.go_start;
          cmd.line_update = 1'b1;
          state_next      = st.go_start ? S_LF : S_IDLE;
        end
      end
      S_LF: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_LF;
          state_next   = S_CR;
        end
      end
      S_CR: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_CR;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.conv_mul = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.conv_step = 1'b1;
        state_next    = st.conv_end ? S_DIGIT : S_MUL;
      end
      S_DIGIT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_DIGIT;
          cmd.pop      = 1'b1;
          state_next   = st.dig_last ? S_LF : S_DIGIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/serial_console_start_command_printer.sv
// Serial console command printer.
// Request channel (item_valid/item_ready): mode 0 carries a received character in
// rx_char, mode 1 a sample in sample_value. Result channel (result_valid/
// result_ready) carries one tx_byte per transfer; last marks the final byte of a
// request. A character is taken in S_IDLE and echoed from S_ECHO once the output
// register is free; the next request can be taken in the cycle after the echo is
// issued. Enter on a five-character line with display off first reads the five
// stored bytes; on "start" it then adds LF, CR. A sample, while display is on,
// runs one divide-by-ten step per S_MUL/S_DIV pass (multiply by reciprocal, then
// subtract), up to 10 digits, then sends the digits most significant first and
// LF, CR at one byte per cycle while result_ready stays high. A sample while
// display is off is dropped in the cycle it is taken.
// The controller handles one request at a time; item_ready is high whenever it is
// idle, even while the last byte still waits in the output register.
// A stalled receiver holds the output register and the byte sequencer waits.
// Reset clears the line length, turns display off and empties the output; the
// line store itself is not cleared.
module serial_console_start_command_printer (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        mode,
  input  logic [7:0]  rx_char,
  input  logic [31:0] sample_value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  tx_byte,
  output logic        last
);
  import sccp_pkg::*;

  cmd_t    cmd;
  status_t st;

  sccp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  sccp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .rx_char      (rx_char),
    .sample_value (sample_value),
    .cmd          (cmd),
    .st           (st),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .tx_byte      (tx_byte),
    .last         (last)
  );

endmodule

FILE: sv/sccp_chk.sv
`include "assert_macros.svh"

module sccp_chk (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       mode,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] tx_byte,
  input logic       last
);

  // Stalled result holds its byte
  `SCCP_ASSERT(a_stall_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(tx_byte) && $stable(last), "result changed while stalled")

  // A character always produces at least an echo, so the block goes busy
  `SCCP_ASSERT(a_char_busy, clk, rst, item_valid && item_ready && !mode |=> !item_ready, "character request did not start processing")

  // More bytes pending means no new request is taken
  `SCCP_ASSERT(a_mid_seq, clk, rst, result_valid && !last |-> !item_ready, "request taken in the middle of a byte sequence")

  // Reset empties the output register
  `SCCP_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !result_valid, "result valid after reset")

endmodule

bind serial_console_start_command_printer sccp_chk u_chk (.*);
